>>> src/cnfp_pkg.sv
// Shared types, codes and character constants for the CNF text parser.
`default_nettype none

package cnfp_pkg;

   // Default field widths
   localparam int VARIABLE_BITS_DEF = 20;
   localparam int CLAUSE_BITS_DEF   = 24;
   localparam int POSITION_BITS_DEF = 16;

   // Parser modes
   typedef enum logic [2:0] {
      MODE_LINE,
      MODE_SKIP,
      MODE_HEAD,
      MODE_FORM,
      MODE_DONE
   } mode_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_LITERAL,
      KIND_CLAUSE_END,
      KIND_EMPTY_DONE,
      KIND_ERROR
   } kind_type;

   // Error codes
   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_NOT_P,
      ERR_NOT_CNF,
      ERR_FIELD_MISSING,
      ERR_VAR_RANGE,
      ERR_EARLY_END,
      ERR_LIMIT
   } error_type;

   // Sign and digit state of the number being read
   typedef struct packed {
      logic negative;
      logic digits_open;
   } num_flags_type;

   // Characters
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_P     = 8'h70;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [1:0] CNF_LEN = 2'd3;

   // Expected byte of the "cnf" keyword at a given position
   function automatic logic [7:0] cnf_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = 8'h63;
         2'd1:    ch = 8'h6E;
         2'd2:    ch = 8'h66;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

>>> src/cnf_text_stream_parser_unit.sv
// A request is held in the input register, and its result then in the result register.
// Throughput: one byte per cycle while results are taken; the input register
// and the result register let a new request in while a result waits.
// Reset (synchronous, active high) returns the parser to the preamble; after
// the final result (last clause end, empty done or error) no result follows.
`default_nettype none

module cnf_text_stream_parser_unit #(
   parameter int VARIABLE_BITS = cnfp_pkg::VARIABLE_BITS_DEF,
   parameter int CLAUSE_BITS   = cnfp_pkg::CLAUSE_BITS_DEF,
   parameter int POSITION_BITS = cnfp_pkg::POSITION_BITS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [7:0]                  req_in_byte,
   input  wire logic                        req_end_of_input,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [1:0]                       rsp_result_kind,
   output logic [CLAUSE_BITS-1:0]           rsp_clause_index,
   output logic [POSITION_BITS-1:0]         rsp_literal_position,
   output logic                             rsp_positive,
   output logic [VARIABLE_BITS-1:0]         rsp_variable_index,
   output logic [2:0]                       rsp_error_code,
   output logic                             rsp_last
);

   // Input register
   logic                            in_valid_ff, in_valid_in;
   logic [7:0]                      in_byte_ff;
   logic                            in_eof_ff;

   // Result register
   logic                            rsp_valid_ff, rsp_valid_in;
   cnfp_pkg::kind_type              kind_ff;
   logic [CLAUSE_BITS-1:0]          clause_ff;
   logic [POSITION_BITS-1:0]        position_ff;
   logic                            positive_ff;
   logic [VARIABLE_BITS-1:0]        variable_ff;
   cnfp_pkg::error_type             error_ff;
   logic                            last_ff;

   // Core result
   logic                            step;
   logic                            res_valid;
   cnfp_pkg::kind_type              res_kind;
   logic [CLAUSE_BITS-1:0]          res_clause;
   logic [POSITION_BITS-1:0]        res_position;
   logic                            res_positive;
   logic [VARIABLE_BITS-1:0]        res_variable;
   cnfp_pkg::error_type             res_error;
   logic                            res_last;

   // Process the held request when the result slot is free or draining
   assign step      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   cnfp_core #(
      .VARIABLE_BITS (VARIABLE_BITS),
      .CLAUSE_BITS   (CLAUSE_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .in_byte      (in_byte_ff),
      .in_eof       (in_eof_ff),
      .res_valid    (res_valid),
      .res_kind     (res_kind),
      .res_clause   (res_clause),
      .res_position (res_position),
      .res_positive (res_positive),
      .res_variable (res_variable),
      .res_error    (res_error),
      .res_last     (res_last)
   );

   // Hold or refill the input register
   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   // Load a new result or drop a taken one
   always_comb begin
      if (step && res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture request payload
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_eof_ff  <= req_end_of_input;
      end
   end

   // Capture result payload
   always_ff @(posedge clock) begin
      if (step && res_valid) begin
         kind_ff     <= res_kind;
         clause_ff   <= res_clause;
         position_ff <= res_position;
         positive_ff <= res_positive;
         variable_ff <= res_variable;
         error_ff    <= res_error;
         last_ff     <= res_last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_result_kind      = kind_ff;
   assign rsp_clause_index     = clause_ff;
   assign rsp_literal_position = position_ff;
   assign rsp_positive         = positive_ff;
   assign rsp_variable_index   = variable_ff;
   assign rsp_error_code       = error_ff;
   assign rsp_last             = last_ff;

endmodule

`default_nettype wire

>>> src/cnfp_acc.sv
// Number accumulator step: atoi rules for one byte of a token.
`default_nettype none

module cnfp_acc #(
   parameter int ACC_W = 33
) (
   input  wire logic [7:0]                    in_byte,
   input  wire logic                          first,
   input  wire logic [ACC_W-1:0]              accum_cur,
   input  wire cnfp_pkg::num_flags_type       flags_cur,
   output logic [ACC_W-1:0]                   accum_next,
   output cnfp_pkg::num_flags_type            flags_next
);

   localparam logic [ACC_W-1:0] ACC_CAP = {1'b1, {(ACC_W-1){1'b0}}};

   logic [ACC_W-1:0]           accum_base;
   cnfp_pkg::num_flags_type    flags_base;
   logic [ACC_W+3:0]           scaled;
   logic                       is_digit;
   logic                       is_sign;

   // Restart the number on the first byte of a token
   always_comb begin
      accum_base = first ? '0 : accum_cur;
      flags_base = flags_cur;
      if (first) begin
         flags_base.negative    = 1'b0;
         flags_base.digits_open = 1'b1;
      end
   end

   assign is_digit = (in_byte >= cnfp_pkg::CH_ZERO) && (in_byte <= cnfp_pkg::CH_NINE);
   assign is_sign  = (in_byte == cnfp_pkg::CH_MINUS) || (in_byte == cnfp_pkg::CH_PLUS);

   // Multiply by ten with shifts and add the digit
   assign scaled = ({4'b0, accum_base} << 3) + ({4'b0, accum_base} << 1)
                 + {{ACC_W{1'b0}}, in_byte[3:0]};

   // Apply sign, digit or stop the digit run; saturate at the cap
   always_comb begin
      accum_next = accum_base;
      flags_next = flags_base;
      if (first && is_sign) begin
         flags_next.negative = (in_byte == cnfp_pkg::CH_MINUS);
      end else if (flags_base.digits_open && is_digit) begin
         if (scaled > {4'b0, ACC_CAP}) begin
            accum_next = ACC_CAP;
         end else begin
            accum_next = scaled[ACC_W-1:0];
         end
      end else begin
         flags_next.digits_open = 1'b0;
      end
   end

endmodule

`default_nettype wire

>>> src/cnfp_core.sv
// Parser state and single-step decode of one request into at most one result.
`default_nettype none

module cnfp_core #(
   parameter int VARIABLE_BITS = cnfp_pkg::VARIABLE_BITS_DEF,
   parameter int CLAUSE_BITS   = cnfp_pkg::CLAUSE_BITS_DEF,
   parameter int POSITION_BITS = cnfp_pkg::POSITION_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [7:0]               in_byte,
   input  wire logic                     in_eof,
   output logic                          res_valid,
   output cnfp_pkg::kind_type            res_kind,
   output logic [CLAUSE_BITS-1:0]        res_clause,
   output logic [POSITION_BITS-1:0]      res_position,
   output logic                          res_positive,
   output logic [VARIABLE_BITS-1:0]      res_variable,
   output cnfp_pkg::error_type           res_error,
   output logic                          res_last
);

   localparam int ACC_MAG = (VARIABLE_BITS > CLAUSE_BITS) ? VARIABLE_BITS : CLAUSE_BITS;
   localparam int ACC_W   = ACC_MAG + 1;

   // State registers
   cnfp_pkg::mode_type          mode_ff, mode_in;
   logic [1:0]                  field_ff, field_in;
   logic                        complete_ff, complete_in;
   logic [1:0]                  cc_ff, cc_in;
   logic [ACC_W-1:0]            accum_ff, accum_in;
   cnfp_pkg::num_flags_type     flags_ff, flags_in;
   logic                        inside_ff, inside_in;
   logic [VARIABLE_BITS-1:0]    limit_ff, limit_in;
   logic [CLAUSE_BITS-1:0]      total_ff, total_in;
   logic [CLAUSE_BITS-1:0]      clause_ff, clause_in;
   logic [POSITION_BITS:0]      pos_ff, pos_in;

   // Decode helpers
   logic                        is_sep;
   logic                        first;
   logic [1:0]                  cc_eff;
   logic [ACC_W-1:0]            accum_nx;
   cnfp_pkg::num_flags_type     flags_nx;

   cnfp_pkg::error_type         hte_err;
   logic [1:0]                  hte_field;
   logic [VARIABLE_BITS-1:0]    hte_limit;
   logic [CLAUSE_BITS-1:0]      hte_total;
   logic                        hte_complete;
   logic                        hc_after;
   logic [CLAUSE_BITS-1:0]      total_after;

   logic                        fte_zero;
   logic                        fte_last;
   cnfp_pkg::error_type         fte_err;
   logic                        fte_final;
   logic [ACC_W-1:0]            accum_less;

   logic                        take_fte;
   logic                        fail_en;
   cnfp_pkg::error_type         fail_code;

   cnfp_acc #(
      .ACC_W (ACC_W)
   ) u_acc (
      .in_byte    (in_byte),
      .first      (first),
      .accum_cur  (accum_ff),
      .flags_cur  (flags_ff),
      .accum_next (accum_nx),
      .flags_next (flags_nx)
   );

   always_comb begin
      is_sep = in_byte inside {cnfp_pkg::CH_SPACE, cnfp_pkg::CH_TAB,
                               cnfp_pkg::CH_CR, cnfp_pkg::CH_LF};
   end

   assign first  = !inside_ff;
   assign cc_eff = first ? 2'd0 : cc_ff;

   // Close a header token: check the field and latch the counts
   always_comb begin
      hte_err      = cnfp_pkg::ERR_NONE;
      hte_field    = field_ff;
      hte_limit    = limit_ff;
      hte_total    = total_ff;
      hte_complete = complete_ff;
      if (!complete_ff) begin
         case (field_ff)
            2'd0: begin
               hte_field = 2'd1;
            end
            2'd1: begin
               if (cc_ff != cnfp_pkg::CNF_LEN) begin
                  hte_err = cnfp_pkg::ERR_NOT_CNF;
               end else begin
                  hte_field = 2'd2;
               end
            end
            2'd2: begin
               if ((flags_ff.negative && accum_ff != '0) ||
                   ((accum_ff >> VARIABLE_BITS) != '0)) begin
                  hte_err = cnfp_pkg::ERR_LIMIT;
               end else begin
                  hte_limit = accum_ff[VARIABLE_BITS-1:0];
                  hte_field = 2'd3;
               end
            end
            default: begin
               if ((flags_ff.negative && accum_ff != '0) ||
                   ((accum_ff >> CLAUSE_BITS) != '0)) begin
                  hte_err = cnfp_pkg::ERR_LIMIT;
               end else begin
                  hte_total    = accum_ff[CLAUSE_BITS-1:0];
                  hte_complete = 1'b1;
               end
            end
         endcase
      end
   end

   assign hc_after    = inside_ff ? hte_complete : complete_ff;
   assign total_after = inside_ff ? hte_total : total_ff;

   // Close a formula token: clause end, literal or error
   assign fte_zero   = (accum_ff == '0);
   assign fte_last   = (({1'b0, clause_ff} + 1'b1) == {1'b0, total_ff});
   assign accum_less = accum_ff - 1'b1;

   always_comb begin
      if (fte_zero) begin
         fte_err = cnfp_pkg::ERR_NONE;
      end else if (accum_ff > {{(ACC_W-VARIABLE_BITS){1'b0}}, limit_ff}) begin
         fte_err = cnfp_pkg::ERR_VAR_RANGE;
      end else if (pos_ff[POSITION_BITS]) begin
         fte_err = cnfp_pkg::ERR_LIMIT;
      end else begin
         fte_err = cnfp_pkg::ERR_NONE;
      end
   end

   assign fte_final = fte_zero ? fte_last : (fte_err != cnfp_pkg::ERR_NONE);

   // Next state and result for one request
   always_comb begin
      mode_in      = mode_ff;
      field_in     = field_ff;
      complete_in  = complete_ff;
      cc_in        = cc_ff;
      accum_in     = accum_ff;
      flags_in     = flags_ff;
      inside_in    = inside_ff;
      limit_in     = limit_ff;
      total_in     = total_ff;
      clause_in    = clause_ff;
      pos_in       = pos_ff;
      res_valid    = 1'b0;
      res_kind     = cnfp_pkg::KIND_LITERAL;
      res_clause   = '0;
      res_position = '0;
      res_positive = 1'b0;
      res_variable = '0;
      res_error    = cnfp_pkg::ERR_NONE;
      res_last     = 1'b0;
      take_fte     = 1'b0;
      fail_en      = 1'b0;
      fail_code    = cnfp_pkg::ERR_NONE;

      case (mode_ff)
         cnfp_pkg::MODE_LINE: begin
            if (in_eof) begin
               fail_en   = 1'b1;
               fail_code = cnfp_pkg::ERR_EARLY_END;
            end else if (!is_sep) begin
               if (in_byte == cnfp_pkg::CH_P) begin
                  mode_in     = cnfp_pkg::MODE_HEAD;
                  field_in    = 2'd0;
                  complete_in = 1'b0;
                  inside_in   = 1'b1;
                  cc_in       = 2'd1;
               end else begin
                  mode_in = cnfp_pkg::MODE_SKIP;
               end
            end
         end
         cnfp_pkg::MODE_SKIP: begin
            if (in_eof) begin
               fail_en   = 1'b1;
               fail_code = cnfp_pkg::ERR_EARLY_END;
            end else if (in_byte == cnfp_pkg::CH_LF) begin
               mode_in = cnfp_pkg::MODE_LINE;
            end
         end
         cnfp_pkg::MODE_HEAD: begin
            if (in_eof || is_sep) begin
               if (inside_ff && hte_err != cnfp_pkg::ERR_NONE) begin
                  fail_en   = 1'b1;
                  fail_code = hte_err;
               end else begin
                  if (inside_ff) begin
                     inside_in   = 1'b0;
                     field_in    = hte_field;
                     limit_in    = hte_limit;
                     total_in    = hte_total;
                     complete_in = hte_complete;
                  end
                  // Line end: enter the formula, finish empty, or flag
                  if (in_eof || in_byte == cnfp_pkg::CH_LF) begin
                     if (!hc_after) begin
                        fail_en   = 1'b1;
                        fail_code = cnfp_pkg::ERR_FIELD_MISSING;
                     end else if (total_after == '0) begin
                        res_valid = 1'b1;
                        res_kind  = cnfp_pkg::KIND_EMPTY_DONE;
                        res_last  = 1'b1;
                        mode_in   = cnfp_pkg::MODE_DONE;
                     end else if (in_eof) begin
                        fail_en   = 1'b1;
                        fail_code = cnfp_pkg::ERR_EARLY_END;
                     end else begin
                        mode_in   = cnfp_pkg::MODE_FORM;
                        inside_in = 1'b0;
                        clause_in = '0;
                        pos_in    = '0;
                     end
                  end
               end
            end else begin
               inside_in = 1'b1;
               accum_in  = accum_nx;
               flags_in  = flags_nx;
               if (first) begin
                  cc_in = 2'd0;
               end
               if (!complete_ff) begin
                  if (field_ff == 2'd0) begin
                     fail_en   = 1'b1;
                     fail_code = cnfp_pkg::ERR_NOT_P;
                  end else if (field_ff == 2'd1) begin
                     if (cc_eff != cnfp_pkg::CNF_LEN &&
                         in_byte == cnfp_pkg::cnf_char(cc_eff)) begin
                        cc_in = cc_eff + 2'd1;
                     end else begin
                        fail_en   = 1'b1;
                        fail_code = cnfp_pkg::ERR_NOT_CNF;
                     end
                  end
               end
            end
         end
         cnfp_pkg::MODE_FORM: begin
            if (in_eof) begin
               if (inside_ff && fte_final) begin
                  take_fte = 1'b1;
               end else begin
                  fail_en   = 1'b1;
                  fail_code = cnfp_pkg::ERR_EARLY_END;
               end
            end else if (is_sep) begin
               take_fte = inside_ff;
            end else begin
               inside_in = 1'b1;
               accum_in  = accum_nx;
               flags_in  = flags_nx;
            end
         end
         default: begin
         end
      endcase

      // Emit the formula token result
      if (take_fte) begin
         inside_in = 1'b0;
         if (fte_err != cnfp_pkg::ERR_NONE) begin
            fail_en   = 1'b1;
            fail_code = fte_err;
         end else if (fte_zero) begin
            res_valid  = 1'b1;
            res_kind   = cnfp_pkg::KIND_CLAUSE_END;
            res_clause = clause_ff;
            res_last   = fte_last;
            clause_in  = clause_ff + 1'b1;
            pos_in     = '0;
            if (fte_last) begin
               mode_in = cnfp_pkg::MODE_DONE;
            end
         end else begin
            res_valid    = 1'b1;
            res_kind     = cnfp_pkg::KIND_LITERAL;
            res_clause   = clause_ff;
            res_position = pos_ff[POSITION_BITS-1:0];
            res_positive = !flags_ff.negative;
            res_variable = accum_less[VARIABLE_BITS-1:0];
            pos_in       = pos_ff + 1'b1;
         end
      end

      // Report an error and stop
      if (fail_en) begin
         res_valid    = 1'b1;
         res_kind     = cnfp_pkg::KIND_ERROR;
         res_clause   = '0;
         res_position = '0;
         res_positive = 1'b0;
         res_variable = '0;
         res_error    = fail_code;
         res_last     = 1'b1;
         mode_in      = cnfp_pkg::MODE_DONE;
      end
   end

   // Advance the state on each processed request
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= cnfp_pkg::MODE_LINE;
         field_ff    <= 2'd0;
         complete_ff <= 1'b0;
         cc_ff       <= 2'd0;
         accum_ff    <= '0;
         flags_ff    <= '{negative: 1'b0, digits_open: 1'b1};
         inside_ff   <= 1'b0;
         limit_ff    <= '0;
         total_ff    <= '0;
         clause_ff   <= '0;
         pos_ff      <= '0;
      end else if (step) begin
         mode_ff     <= mode_in;
         field_ff    <= field_in;
         complete_ff <= complete_in;
         cc_ff       <= cc_in;
         accum_ff    <= accum_in;
         flags_ff    <= flags_in;
         inside_ff   <= inside_in;
         limit_ff    <= limit_in;
         total_ff    <= total_in;
         clause_ff   <= clause_in;
         pos_ff      <= pos_in;
      end
   end

   ap_done_sticky: assert property (@(posedge clock) disable iff (reset)
      mode_ff == cnfp_pkg::MODE_DONE |=> mode_ff == cnfp_pkg::MODE_DONE)
      else $error("parser left the finished mode without reset");

   ap_done_quiet: assert property (@(posedge clock) disable iff (reset)
      mode_ff == cnfp_pkg::MODE_DONE |-> !res_valid)
      else $error("result produced after the final result");

   ap_error_last: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res_kind == cnfp_pkg::KIND_ERROR |-> res_last)
      else $error("error result not marked last");

   ap_last_done: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res_last |=> mode_ff == cnfp_pkg::MODE_DONE)
      else $error("final result did not stop the parser");

   ap_complete_field: assert property (@(posedge clock) disable iff (reset)
      complete_ff |-> field_ff == 2'd3)
      else $error("header complete before the clause count field");

endmodule

`default_nettype wire

>>> bench/cnf_text_stream_parser_checker.sv
// Checker for the CNF text parser: watches both channels, predicts results, compares them.
module cnf_text_stream_parser_checker
   import cnfp_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_ready,
   input  wire logic [7:0]                   req_in_byte,
   input  wire logic                         req_end_of_input,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   input  wire logic [1:0]                   rsp_result_kind,
   input  wire logic [CLAUSE_BITS_DEF-1:0]   rsp_clause_index,
   input  wire logic [POSITION_BITS_DEF-1:0] rsp_literal_position,
   input  wire logic                         rsp_positive,
   input  wire logic [VARIABLE_BITS_DEF-1:0] rsp_variable_index,
   input  wire logic [2:0]                   rsp_error_code,
   input  wire logic                         rsp_last,
   output int                                mismatch_count,
   output int                                results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VB = VARIABLE_BITS_DEF;
   localparam int CB = CLAUSE_BITS_DEF;
   localparam int PB = POSITION_BITS_DEF;

   localparam logic [47:0] VAR_TOP    = (48'd1 << VB) - 48'd1;
   localparam logic [47:0] CLAUSE_TOP = (48'd1 << CB) - 48'd1;
   localparam logic [47:0] POS_TOP    = (48'd1 << PB) - 48'd1;
   localparam logic [47:0] MAG_CAP    = 48'd1 << 40;
   localparam logic [23:0] KEYWORD    = "cnf";

   // Header tokens in order of appearance
   typedef enum logic [1:0] {
      FIELD_P,
      FIELD_CNF,
      FIELD_VARS,
      FIELD_CLAUSES
   } head_field_type;

   typedef struct packed {
      kind_type        kind;
      logic [CB-1:0]   clause;
      logic [PB-1:0]   position;
      logic            positive;
      logic [VB-1:0]   var_index;
      error_type       code;
      logic            closing;
   } parse_result_type;

   parse_result_type pending_results[$];

   // Parser state mirror
   mode_type        mode;
   head_field_type  field_no;
   logic [47:0]     magnitude;
   logic            negative;
   logic            digits_live;
   logic            in_token;
   logic [VB-1:0]   var_limit;
   logic [CB-1:0]   clause_goal;
   logic [CB-1:0]   clause_no;
   logic [PB:0]     lit_pos;
   logic            header_done;
   logic [1:0]      kw_count;

   function automatic void reset_parser();
      mode        = MODE_LINE;
      field_no    = FIELD_P;
      magnitude   = '0;
      negative    = 1'b0;
      digits_live = 1'b1;
      in_token    = 1'b0;
      var_limit   = '0;
      clause_goal = '0;
      clause_no   = '0;
      lit_pos     = '0;
      header_done = 1'b0;
      kw_count    = '0;
   endfunction

   function automatic bit is_blank(input logic [7:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
   endfunction

   function automatic void raise_error(input error_type code, output parse_result_type r);
      r = '0;
      r.kind = KIND_ERROR;
      r.code = code;
      r.closing = 1'b1;
      mode = MODE_DONE;
   endfunction

   // Apply one byte of a numeric token with atoi rules
   function automatic void take_digit(input logic [7:0] b, input bit first);
      if (first && (b == CH_MINUS || b == CH_PLUS)) begin
         negative = (b == CH_MINUS);
      end else if (digits_live && b >= CH_ZERO && b <= CH_NINE) begin
         magnitude = magnitude * 10 + (b - CH_ZERO);
         if (magnitude > MAG_CAP)
            magnitude = MAG_CAP;
      end else begin
         digits_live = 1'b0;
      end
   endfunction

   // Close a header token; returns the error it raises, if any
   function automatic error_type close_head_token();
      in_token = 1'b0;
      if (header_done)
         return ERR_NONE;
      case (field_no)
         FIELD_P: field_no = FIELD_CNF;
         FIELD_CNF: begin
            if (kw_count != CNF_LEN)
               return ERR_NOT_CNF;
            field_no = FIELD_VARS;
         end
         FIELD_VARS: begin
            if ((negative && magnitude != 0) || magnitude > VAR_TOP)
               return ERR_LIMIT;
            var_limit = magnitude[VB-1:0];
            field_no = FIELD_CLAUSES;
         end
         default: begin
            if ((negative && magnitude != 0) || magnitude > CLAUSE_TOP)
               return ERR_LIMIT;
            clause_goal = magnitude[CB-1:0];
            header_done = 1'b1;
         end
      endcase
      return ERR_NONE;
   endfunction

   // Close the header line at LF or end of input
   function automatic bit close_head_line(input bit eof, output parse_result_type r);
      r = '0;
      if (!header_done) begin
         raise_error(ERR_FIELD_MISSING, r);
         return 1'b1;
      end
      if (clause_goal == 0) begin
         r.kind = KIND_EMPTY_DONE;
         r.closing = 1'b1;
         mode = MODE_DONE;
         return 1'b1;
      end
      if (eof) begin
         raise_error(ERR_EARLY_END, r);
         return 1'b1;
      end
      mode = MODE_FORM;
      in_token = 1'b0;
      clause_no = '0;
      lit_pos = '0;
      return 1'b0;
   endfunction

   // Close a formula token: a zero ends the clause, else a literal or an error
   function automatic void close_form_token(output parse_result_type r);
      r = '0;
      in_token = 1'b0;
      if (magnitude == 0) begin
         r.kind = KIND_CLAUSE_END;
         r.clause = clause_no;
         r.closing = ((clause_no + 1) == clause_goal);
         clause_no = clause_no + 1'b1;
         lit_pos = '0;
         if (r.closing)
            mode = MODE_DONE;
      end else if (magnitude > var_limit) begin
         raise_error(ERR_VAR_RANGE, r);
      end else if (lit_pos > POS_TOP) begin
         raise_error(ERR_LIMIT, r);
      end else begin
         r.kind = KIND_LITERAL;
         r.clause = clause_no;
         r.position = lit_pos[PB-1:0];
         r.positive = !negative;
         r.var_index = VB'(magnitude - 48'd1);
         lit_pos = lit_pos + 1'b1;
      end
   endfunction

   // Advance the parser by one request; returns 1 when it yields a result
   function automatic bit parse_byte(input logic [7:0] b, input logic eof,
                                     output parse_result_type r);
      error_type e;
      bit first;
      r = '0;
      if (mode == MODE_DONE)
         return 1'b0;
      if (eof) begin
         if (mode == MODE_HEAD) begin
            if (in_token) begin
               e = close_head_token();
               if (e != ERR_NONE) begin
                  raise_error(e, r);
                  return 1'b1;
               end
            end
            return close_head_line(1'b1, r);
         end
         // a pending token is completed first; only a final result survives
         if (mode == MODE_FORM && in_token) begin
            close_form_token(r);
            if (mode == MODE_DONE)
               return 1'b1;
         end
         raise_error(ERR_EARLY_END, r);
         return 1'b1;
      end
      case (mode)
         MODE_LINE: begin
            if (is_blank(b))
               return 1'b0;
            if (b == CH_P) begin
               mode = MODE_HEAD;
               field_no = FIELD_P;
               header_done = 1'b0;
               in_token = 1'b1;
               kw_count = 2'd1;
            end else begin
               mode = MODE_SKIP;
            end
            return 1'b0;
         end
         MODE_SKIP: begin
            if (b == CH_LF)
               mode = MODE_LINE;
            return 1'b0;
         end
         MODE_HEAD: begin
            if (is_blank(b)) begin
               if (in_token) begin
                  e = close_head_token();
                  if (e != ERR_NONE) begin
                     raise_error(e, r);
                     return 1'b1;
                  end
               end
               if (b == CH_LF)
                  return close_head_line(1'b0, r);
               return 1'b0;
            end
            first = !in_token;
            if (first) begin
               in_token = 1'b1;
               kw_count = '0;
               magnitude = '0;
               negative = 1'b0;
               digits_live = 1'b1;
            end
            if (header_done)
               return 1'b0;
            if (field_no == FIELD_P) begin
               raise_error(ERR_NOT_P, r);
               return 1'b1;
            end
            if (field_no == FIELD_CNF) begin
               if (kw_count < CNF_LEN && b == KEYWORD[8 * (2 - kw_count) +: 8]) begin
                  kw_count = kw_count + 1'b1;
                  return 1'b0;
               end
               raise_error(ERR_NOT_CNF, r);
               return 1'b1;
            end
            take_digit(b, first);
            return 1'b0;
         end
         default: begin
            if (is_blank(b)) begin
               if (!in_token)
                  return 1'b0;
               close_form_token(r);
               return 1'b1;
            end
            first = !in_token;
            if (first) begin
               in_token = 1'b1;
               magnitude = '0;
               negative = 1'b0;
               digits_live = 1'b1;
            end
            take_digit(b, first);
            return 1'b0;
         end
      endcase
   endfunction

   // Compare accepted results, then predict from accepted requests
   always @(posedge clock) begin
      parse_result_type got;
      parse_result_type want;
      parse_result_type fresh;
      bit have_want;
      if (reset) begin
         reset_parser();
         pending_results.delete();
         mismatch_count <= 0;
         results_due <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.kind      = kind_type'(rsp_result_kind);
            got.clause    = rsp_clause_index;
            got.position  = rsp_literal_position;
            got.positive  = rsp_positive;
            got.var_index = rsp_variable_index;
            got.code      = error_type'(rsp_error_code);
            got.closing   = rsp_last;
            have_want = (pending_results.size() != 0);
            want = '0;
            if (have_want)
               want = pending_results.pop_front();
            if (!have_want || got !== want) begin
               if (mismatch_count < 10) begin
                  $display("%0t: %s: expected kind %0d clause %0d position %0d positive %0b",
                           $time, have_want ? "result mismatch" : "unexpected result",
                           want.kind, want.clause, want.position, want.positive,
                           " var %0d code %0d last %0b", want.var_index, want.code,
                           want.closing);
                  $display("%0t:   got kind %0d clause %0d position %0d positive %0b",
                           $time, got.kind, got.clause, got.position, got.positive,
                           " var %0d code %0d last %0b", got.var_index, got.code,
                           got.closing);
               end
               mismatch_count <= mismatch_count + 1;
            end
         end
         if (req_valid && req_ready) begin
            if (parse_byte(req_in_byte, req_end_of_input, fresh))
               pending_results.push_back(fresh);
         end
         results_due <= pending_results.size();
      end
   end

endmodule

>>> bench/cnf_text_stream_parser_unit_test.sv
// Testbench top for the CNF text parser: builds one CNF text, streams it, gives the verdict.
module cnf_text_stream_parser_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import cnfp_pkg::*;

   localparam int VAR_CEIL = (1 << VARIABLE_BITS_DEF) - 1;
   // Quiet stretches are geometric in the idle and stall odds; this leaves a wide margin
   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 8;

   // How the text ends
   typedef enum int {
      FINISH_CLEAN,
      FINISH_AT_EOF,
      FINISH_EARLY,
      FINISH_BAD_VAR
   } finish_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [7:0]                    req_in_byte = '0;
   logic                          req_end_of_input = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [1:0]                    rsp_result_kind;
   logic [CLAUSE_BITS_DEF-1:0]    rsp_clause_index;
   logic [POSITION_BITS_DEF-1:0]  rsp_literal_position;
   logic                          rsp_positive;
   logic [VARIABLE_BITS_DEF-1:0]  rsp_variable_index;
   logic [2:0]                    rsp_error_code;
   logic                          rsp_last;

   int mismatch_count;
   int results_due;
   int sender_idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   bit stimulus_done = 1'b0;
   logic [7:0] text_q[$];

   cnf_text_stream_parser_unit dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_in_byte          (req_in_byte),
      .req_end_of_input     (req_end_of_input),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_clause_index     (rsp_clause_index),
      .rsp_literal_position (rsp_literal_position),
      .rsp_positive         (rsp_positive),
      .rsp_variable_index   (rsp_variable_index),
      .rsp_error_code       (rsp_error_code),
      .rsp_last             (rsp_last)
   );

   cnf_text_stream_parser_checker u_checker (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_in_byte          (req_in_byte),
      .req_end_of_input     (req_end_of_input),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result_kind      (rsp_result_kind),
      .rsp_clause_index     (rsp_clause_index),
      .rsp_literal_position (rsp_literal_position),
      .rsp_positive         (rsp_positive),
      .rsp_variable_index   (rsp_variable_index),
      .rsp_error_code       (rsp_error_code),
      .rsp_last             (rsp_last),
      .mismatch_count       (mismatch_count),
      .results_due          (results_due)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Stall the result channel at the current odds
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // End the run when nothing moves while work is outstanding
   always @(posedge clock) begin
      if (reset || (stimulus_done && results_due == 0) ||
          (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("cnf_text_stream_parser_unit_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++)
         text_q.push_back(s[i]);
   endfunction

   // Random non-blank byte; a lead byte is neither a digit nor a sign
   function automatic logic [7:0] junk_byte(input bit lead);
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF ||
             (lead && ((b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS || b == CH_PLUS)));
      return b;
   endfunction

   function automatic void put_gap();
      case ($urandom_range(7))
         0: put_text("\t");
         1: put_text("\n");
         2: put_text("\r\n");
         3: put_text("  ");
         default: put_text(" ");
      endcase
   endfunction

   // Literal token: optional sign, optional leading zero, digits, optional tail
   function automatic void put_literal();
      int v;
      case ($urandom_range(19))
         0: v = VAR_CEIL;
         1, 2, 3: v = $urandom_range(VAR_CEIL, 1);
         default: v = $urandom_range(40, 1);
      endcase
      case ($urandom_range(9))
         0, 1, 2, 3: put_text("-");
         4: put_text("+");
         default: ;
      endcase
      if ($urandom_range(7) == 0)
         put_text("0");
      put_text($sformatf("%0d", v));
      if ($urandom_range(5) == 0) begin
         text_q.push_back(junk_byte(1'b1));
         repeat ($urandom_range(2)) text_q.push_back(junk_byte(1'b0));
      end
   endfunction

   // Token whose value reads as zero
   function automatic void put_clause_end();
      case ($urandom_range(9))
         5: put_text("-0");
         6: put_text("+0");
         7: put_text("000");
         8: begin
            put_text("0");
            text_q.push_back(junk_byte(1'b1));
         end
         9: begin
            text_q.push_back($urandom_range(1) ? CH_MINUS : junk_byte(1'b1));
            repeat ($urandom_range(2)) text_q.push_back(junk_byte(1'b1));
         end
         default: put_text("0");
      endcase
   endfunction

   task automatic deliver(input logic [7:0] b, input logic eof);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      req_end_of_input <= eof;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   initial begin
      finish_type ending;
      logic [7:0] body_q[$];
      logic [7:0] b;
      int clauses;
      int goal;
      int total;
      int pause_at;

      ending = finish_type'($urandom_range(3));

      // Formula body: extreme variables and an empty clause first
      put_text($sformatf("1 -%0d +2 0\n0\n", VAR_CEIL));
      clauses = 2;
      while (text_q.size() < 1860) begin
         repeat ($urandom_range(5)) begin
            put_literal();
            put_gap();
         end
         put_clause_end();
         put_gap();
         clauses++;
      end

      // Tail that decides how parsing ends
      case (ending)
         FINISH_CLEAN: begin
            goal = clauses;
            put_text("5 -6 0\n");
         end
         FINISH_AT_EOF: begin
            goal = clauses + 1;
            put_literal();
            put_gap();
            put_clause_end();
         end
         FINISH_EARLY: begin
            goal = clauses + 1 + $urandom_range(3);
            put_literal();
            put_gap();
            put_literal();
         end
         default: begin
            goal = clauses + 1;
            put_literal();
            put_gap();
            if ($urandom_range(1))
               put_text($sformatf("%0d", VAR_CEIL + 1));
            else
               put_text("-12345678901234567890");
            put_text(" 3 0\n");
         end
      endcase
      body_q = text_q;
      text_q.delete();

      // Preamble: blank line, comment, stray line, then the header
      put_text(" \t\r\nc ");
      repeat (12) text_q.push_back(junk_byte(1'b0));
      put_text("\n\n");
      do
         b = junk_byte(1'b1);
      while (b == CH_P);
      text_q.push_back(b);
      repeat (12) text_q.push_back(junk_byte(1'b0));
      put_text($sformatf("\n p\tcnf  +%0d\t0%0d extra 7\r\n", VAR_CEIL, goal));
      text_q = {text_q, body_q};

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      total = text_q.size();
      pause_at = total / 2;
      for (int i = 0; i < total; i++) begin
         // Idle and stall phases over the stream
         case (i * 5 / total)
            1: begin
               sender_idle_pct = 68;
               stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               stall_pct = 68;
            end
            3: begin
               sender_idle_pct = 18;
               stall_pct = 18;
            end
            default: begin
               sender_idle_pct = 0;
               stall_pct = 0;
            end
         endcase
         // Hold the sender until every expected result has come
         if (i == pause_at) begin
            req_valid <= 1'b0;
            @(negedge clock);
            while (results_due != 0) @(negedge clock);
         end
         deliver(text_q[i], 1'b0);
      end
      deliver(8'($urandom_range(255)), 1'b1);
      repeat (2) deliver(8'($urandom_range(255)), 1'b0);
      req_valid <= 1'b0;
      sender_idle_pct = 0;
      stall_pct = 0;
      stimulus_done = 1'b1;

      // Drain
      while (results_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && results_due == 0)
         $display("cnf_text_stream_parser_unit_test: clean");
      else
         $display("cnf_text_stream_parser_unit_test: errors");
      $finish;
   end

endmodule
